>>> rtl/tkis_pkg.sv
// Shared types and constants for the top-k index selector.
// Depends on nothing; imported by tkis_store and top_k_index_select.
`timescale 1ns / 1ps
`default_nettype none

package tkis_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int CNT_W   = 7;

  // one kept list entry
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } entry_t;

  // memory port enables
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_REPORT
  } state_t;

endpackage

`default_nettype wire

>>> rtl/top_k_index_select.sv
// An item is written straight to the head when the list is empty and is not stored when it
// is past MAX_ITEMS; otherwise the insertion walks the list from its tail, one entry per
// cycle through the single memory read port.
// Report: after the set_end item, min(pick_count, kept) positions follow one per cycle,
// each read in ST_REPORT and shown with result_valid from the registered read data.
// Reset clears control and counters and sets pick_count to 1; the list memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module top_k_index_select
  import tkis_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CNT_W-1:0]          cfg_wdata,
  input  wire logic                      start,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic                      set_end,
  output logic                           busy,
  output logic                           result_valid,
  output logic [POS_W-1:0]               position,
  output logic                           run_end
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] pick_count;
  logic [CNT_W-1:0] kept_count;
  logic [CNT_W-1:0] arrival_count;
  logic [CNT_W-1:0] rpt_idx;
  logic [AW-1:0]    cur;
  logic             last_flag;
  entry_t           key;

  store_req_t       req;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;
  logic             shift;

  logic             accept;
  logic             accept_ins;
  logic             kept_empty;
  logic [CNT_W-1:0] rpt_count;
  logic             rpt_last;
  entry_t           in_entry;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign accept_ins = accept && (arrival_count < MAX_CNT);
  assign kept_empty = (kept_count == '0);
  assign in_entry   = '{value: value, position: arrival_count[POS_W-1:0]};
  assign rpt_count  = (pick_count < kept_count) ? pick_count : kept_count;
  assign rpt_last   = ((rpt_idx + CNT_W'(1)) == rpt_count);
  assign position   = rd_data.position;

  // list memory
  tkis_store #(
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk       (clk),
    .req       (req),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .key_value (key.value),
    .rd_data   (rd_data),
    .shift     (shift)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (accept_ins && !kept_empty) begin
            state_next = ST_SCAN;
          end else if (set_end) begin
            state_next = ST_REPORT;
          end
        end
      end
      ST_SCAN: begin
        if (shift) begin
          if (cur == '0) begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = last_flag ? ST_REPORT : ST_IDLE;
        end
      end
      ST_PLACE: begin
        state_next = last_flag ? ST_REPORT : ST_IDLE;
      end
      ST_REPORT: begin
        if (rpt_count == '0 || rpt_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    req     = '0;
    wr_addr = '0;
    wr_data = key;
    rd_addr = '0;
    case (state)
      ST_IDLE: begin
        wr_data = in_entry;
        if (accept_ins) begin
          if (kept_empty) begin
            req.wr_en = 1'b1;
          end else begin
            req.rd_en = 1'b1;
            rd_addr   = AW'(kept_count - CNT_W'(1));
          end
        end
      end
      ST_SCAN: begin
        req.wr_en = 1'b1;
        wr_addr   = cur + AW'(1);
        if (shift) begin
          wr_data = rd_data;
          if (cur != '0) begin
            req.rd_en = 1'b1;
            rd_addr   = cur - AW'(1);
          end
        end
      end
      ST_PLACE: begin
        req.wr_en = 1'b1;
      end
      ST_REPORT: begin
        if (rpt_count != '0) begin
          req.rd_en = 1'b1;
          rd_addr   = rpt_idx[AW-1:0];
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pick_count    <= CNT_W'(1);
      kept_count    <= '0;
      arrival_count <= '0;
      rpt_idx       <= '0;
      result_valid  <= 1'b0;
      run_end       <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      run_end      <= 1'b0;
      if (cfg_we) begin
        pick_count <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (accept_ins) begin
            arrival_count <= arrival_count + CNT_W'(1);
            if (kept_empty) begin
              kept_count <= CNT_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (!shift) begin
            kept_count <= kept_count + CNT_W'(1);
          end
        end
        ST_PLACE: begin
          kept_count <= kept_count + CNT_W'(1);
        end
        ST_REPORT: begin
          if (rpt_count == '0) begin
            kept_count    <= '0;
            arrival_count <= '0;
            rpt_idx       <= '0;
          end else begin
            result_valid <= 1'b1;
            run_end      <= rpt_last;
            if (rpt_last) begin
              kept_count    <= '0;
              arrival_count <= '0;
              rpt_idx       <= '0;
            end else begin
              rpt_idx <= rpt_idx + CNT_W'(1);
            end
          end
        end
        default: begin
          rpt_idx <= '0;
        end
      endcase
    end
  end

  // item payload and scan pointer
  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= in_entry;
      last_flag <= set_end;
      cur       <= AW'(kept_count - CNT_W'(1));
    end else if (state == ST_SCAN && shift && cur != '0) begin
      cur <= cur - AW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_result_from_report: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == ST_REPORT)
    else $error("result shown outside a report");

  a_run_end_strobe: assert property (@(posedge clk) disable iff (rst)
    run_end |-> result_valid)
    else $error("run_end without result strobe");

  a_kept_le_arrival: assert property (@(posedge clk) disable iff (rst)
    kept_count <= arrival_count && arrival_count <= MAX_CNT)
    else $error("list count exceeds arrivals or capacity");

  a_scan_in_list: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CNT_W'(cur) < kept_count)
    else $error("scan pointer outside kept list");

  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && state_next == ST_IDLE) |=> kept_count == '0)
    else $error("list not cleared after report");
`endif

endmodule

`default_nettype wire

>>> rtl/tkis_store.sv
// Sorted list storage: one-write one-read memory with registered read data,
// plus the ordering compare of the read entry against the item being inserted.
// Depends on tkis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkis_store
  import tkis_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire store_req_t                req,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire entry_t                    wr_data,
  input  wire logic [AW-1:0]             rd_addr,
  input  wire logic signed [VALUE_W-1:0] key_value,
  output entry_t                         rd_data,
  output logic                           shift
);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // stored entry strictly below the new value moves one slot toward the tail
  assign shift = $signed(rd_data.value) < $signed(key_value);

endmodule

`default_nettype wire
